// ===== rtl/core/csim_pkg.sv =====
// ----------------------------------------------------------------------------
// csim_pkg
// Shared widths, limits and sequencer states of the cosine similarity engine.
// ----------------------------------------------------------------------------
package csim_pkg;

   localparam int ElemWidth = 16;
   localparam int AccWidth  = 48;
   localparam int RootWidth = AccWidth / 2;
   localparam int NumWidth  = AccWidth + ElemWidth - 1;
   localparam int QuoWidth  = ElemWidth + 1;
   localparam int MulWidth  = RootWidth + 1;
   localparam int ProdWidth = 2 * MulWidth;
   localparam int CntWidth  = $clog2(RootWidth);

   localparam logic [QuoWidth-1:0] PosLimit = QuoWidth'(32767);
   localparam logic [QuoWidth-1:0] NegLimit = QuoWidth'(32768);

   localparam logic signed [ElemWidth-1:0] SimMax = 16'sh7FFF;
   localparam logic signed [ElemWidth-1:0] SimMin = 16'sh8000;

   typedef enum logic [12:0] {
      ST_IDLE        = 13'b0000000000001,
      ST_MUL_AB      = 13'b0000000000010,
      ST_MUL_AA      = 13'b0000000000100,
      ST_MUL_BB      = 13'b0000000001000,
      ST_ACC_BB      = 13'b0000000010000,
      ST_ROOT_A_GO   = 13'b0000000100000,
      ST_ROOT_A_WAIT = 13'b0000001000000,
      ST_ROOT_B_GO   = 13'b0000010000000,
      ST_ROOT_B_WAIT = 13'b0000100000000,
      ST_DEN_MUL     = 13'b0001000000000,
      ST_DIV_GO      = 13'b0010000000000,
      ST_DIV_WAIT    = 13'b0100000000000,
      ST_FINISH      = 13'b1000000000000
   } csim_state_type;

   typedef struct packed {
      logic done;
      logic ovf;
   } csim_div_status_type;

endpackage

// ===== rtl/core/csim_isqrt.sv =====
// ----------------------------------------------------------------------------
// csim_isqrt
// Bit-pair integer square root of a 48-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module csim_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [csim_pkg::AccWidth-1:0]   value,
   output logic                            done,
   output logic [csim_pkg::RootWidth-1:0]  root
);

   logic                            busy_ff, busy_in;
   logic [csim_pkg::CntWidth-1:0]   cnt_ff, cnt_in;
   logic [csim_pkg::AccWidth-1:0]   rem_ff, rem_in;
   logic [csim_pkg::AccWidth-1:0]   res_ff, res_in;
   logic [csim_pkg::AccWidth-1:0]   bit_w;
   logic [csim_pkg::AccWidth:0]     trial;
   logic                            take;

   // test bit is 4^cnt
   assign bit_w = csim_pkg::AccWidth'(1) << {cnt_ff, 1'b0};
   assign trial = {1'b0, res_ff} + {1'b0, bit_w};
   assign take  = {1'b0, rem_ff} >= trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = csim_pkg::CntWidth'(csim_pkg::RootWidth - 1);
         rem_in  = value;
         res_in  = '0;
      end else if (busy_ff) begin
         if (take) begin
            rem_in = rem_ff - trial[csim_pkg::AccWidth-1:0];
            res_in = (res_ff >> 1) + bit_w;
         end else begin
            res_in = res_ff >> 1;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign done = busy_ff && (cnt_ff == '0);
   assign root = res_ff[csim_pkg::RootWidth-1:0];

endmodule

// ===== rtl/core/csim_div.sv =====
// ----------------------------------------------------------------------------
// csim_div
// Restoring divider giving a 17-bit quotient, one bit per cycle, with a
// flag for quotients that do not fit.
// ----------------------------------------------------------------------------
module csim_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [csim_pkg::NumWidth-1:0]   num,
   input  logic [csim_pkg::AccWidth-1:0]   den,
   output csim_pkg::csim_div_status_type   status,
   output logic [csim_pkg::QuoWidth-1:0]   quo
);

   localparam int ShWidth = csim_pkg::AccWidth + csim_pkg::ElemWidth;

   logic                            busy_ff, busy_in;
   logic [csim_pkg::CntWidth-1:0]   cnt_ff, cnt_in;
   logic [csim_pkg::NumWidth-1:0]   rem_ff, rem_in;
   logic [ShWidth-1:0]              dsh_ff, dsh_in;
   logic [csim_pkg::QuoWidth-1:0]   quo_ff, quo_in;
   logic                            ovf_ff, ovf_in;
   logic                            take;

   assign take = {1'b0, rem_ff} >= dsh_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = csim_pkg::CntWidth'(csim_pkg::QuoWidth - 1);
         rem_in  = num;
         dsh_in  = {den, csim_pkg::ElemWidth'(0)};
         quo_in  = '0;
         // quotient of 2^17 or more cannot be represented
         ovf_in  = {2'b00, num} >= {den, csim_pkg::QuoWidth'(0)};
      end else if (busy_ff) begin
         if (take) begin
            rem_in = rem_ff - dsh_ff[csim_pkg::NumWidth-1:0];
         end
         quo_in = {quo_ff[csim_pkg::QuoWidth-2:0], take};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign status.done = busy_ff && (cnt_ff == '0);
   assign status.ovf  = ovf_ff;
   assign quo         = quo_ff;

endmodule

// ===== rtl/core/cosine_similarity_engine.sv =====
// ----------------------------------------------------------------------------
// cosine_similarity_engine
// Streaming cosine similarity of two Q1.15 vectors, one element pair per
// request, result dot / sqrt(|a|^2 * |b|^2) in saturated Q1.15.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  --------+-----------+-----------------------------------------------
//  req     | in        | req_valid/ready, req_elem_a, req_elem_b, req_last_pair
//  rsp     | out       | rsp_valid/ready, rsp_similarity, rsp_zero_norm
//
//  Each pair steps through MUL_AB, MUL_AA, MUL_BB and ACC_BB: one 25x25
//  multiplier is shared for a*b, a*a, b*b. The last pair then adds two
//  24-step roots on one shared root unit, the denominator product on the
//  same multiplier and a 17-step divide, skipped when a norm is zero.
//  Reset is synchronous and clears the sums and the sequencer.
//  A result waits in the output register; the next vector may stream in
//  meanwhile, and only its final step stalls until the result is taken.
// ----------------------------------------------------------------------------
module cosine_similarity_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [csim_pkg::ElemWidth-1:0] req_elem_a,
   input  logic signed [csim_pkg::ElemWidth-1:0] req_elem_b,
   input  logic                                  req_last_pair,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [csim_pkg::ElemWidth-1:0] rsp_similarity,
   output logic                                  rsp_zero_norm
);

   localparam int AccW  = csim_pkg::AccWidth;
   localparam int ElemW = csim_pkg::ElemWidth;

   csim_pkg::csim_state_type state_ff, state_in;

   logic signed [ElemW-1:0]               a_ff, a_in, b_ff, b_in;
   logic                                  last_ff, last_in;
   logic signed [AccW-1:0]                dot_ff, dot_in;
   logic [AccW-1:0]                       na_ff, na_in, nb_ff, nb_in;
   logic [csim_pkg::RootWidth-1:0]        sa_ff, sa_in;
   logic signed [csim_pkg::ProdWidth-1:0] prod_ff, prod_in;
   logic                                  zero_ff, zero_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [ElemW-1:0]               sim_ff, sim_in;
   logic                                  zn_ff, zn_in;

   logic signed [csim_pkg::MulWidth-1:0]  mul_x, mul_y;
   logic signed [AccW:0]                  dot_sum;
   logic [AccW:0]                         na_sum, nb_sum;

   logic                                  root_start;
   logic [AccW-1:0]                       root_value;
   logic                                  root_done;
   logic [csim_pkg::RootWidth-1:0]        root;

   logic                                  div_start;
   logic [AccW-1:0]                       den;
   logic [AccW-1:0]                       dot_mag;
   logic [csim_pkg::NumWidth-1:0]         num;
   csim_pkg::csim_div_status_type         div_status;
   logic [csim_pkg::QuoWidth-1:0]         quo;
   logic [csim_pkg::QuoWidth-1:0]         quo_neg;
   logic                                  dot_neg;
   logic                                  out_free;

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         csim_pkg::ST_MUL_AB: begin
            mul_x = csim_pkg::MulWidth'(a_ff);
            mul_y = csim_pkg::MulWidth'(b_ff);
         end
         csim_pkg::ST_MUL_AA: begin
            mul_x = csim_pkg::MulWidth'(a_ff);
            mul_y = csim_pkg::MulWidth'(a_ff);
         end
         csim_pkg::ST_MUL_BB: begin
            mul_x = csim_pkg::MulWidth'(b_ff);
            mul_y = csim_pkg::MulWidth'(b_ff);
         end
         default: begin
            mul_x = $signed({1'b0, sa_ff});
            mul_y = $signed({1'b0, root});
         end
      endcase
   end

   assign prod_in = mul_x * mul_y;

   // products of Q1.15 pairs fit in 32 bits
   assign dot_sum = {dot_ff[AccW-1], dot_ff} + (AccW+1)'($signed(prod_ff[31:0]));
   assign na_sum  = {1'b0, na_ff} + (AccW+1)'(prod_ff[31:0]);
   assign nb_sum  = {1'b0, nb_ff} + (AccW+1)'(prod_ff[31:0]);

   assign dot_neg = dot_ff[AccW-1];
   assign dot_mag = dot_neg ? AccW'(-dot_ff) : AccW'(dot_ff);
   assign den     = prod_ff[AccW-1:0];
   assign num     = {dot_mag, (ElemW-1)'(0)} + {ElemW'(0), den[AccW-1:1]};
   assign quo_neg = -quo;

   assign root_start = (state_ff == csim_pkg::ST_ROOT_A_GO) ||
                       (state_ff == csim_pkg::ST_ROOT_B_GO);
   assign root_value = (state_ff == csim_pkg::ST_ROOT_A_GO) ? na_ff : nb_ff;
   assign div_start  = (state_ff == csim_pkg::ST_DIV_GO) && (den != '0);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      last_in      = last_ff;
      dot_in       = dot_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      sa_in        = sa_ff;
      zero_in      = zero_ff;
      sim_in       = sim_ff;
      zn_in        = zn_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         csim_pkg::ST_IDLE: begin
            if (req_valid) begin
               a_in     = req_elem_a;
               b_in     = req_elem_b;
               last_in  = req_last_pair;
               state_in = csim_pkg::ST_MUL_AB;
            end
         end
         csim_pkg::ST_MUL_AB: begin
            state_in = csim_pkg::ST_MUL_AA;
         end
         csim_pkg::ST_MUL_AA: begin
            if (dot_sum[AccW] != dot_sum[AccW-1]) begin
               dot_in = dot_sum[AccW] ? csim_pkg::AccWidth'({1'b1, (AccW-1)'(0)})
                                      : csim_pkg::AccWidth'({1'b0, {(AccW-1){1'b1}}});
            end else begin
               dot_in = dot_sum[AccW-1:0];
            end
            state_in = csim_pkg::ST_MUL_BB;
         end
         csim_pkg::ST_MUL_BB: begin
            na_in    = na_sum[AccW] ? '1 : na_sum[AccW-1:0];
            state_in = csim_pkg::ST_ACC_BB;
         end
         csim_pkg::ST_ACC_BB: begin
            nb_in    = nb_sum[AccW] ? '1 : nb_sum[AccW-1:0];
            state_in = last_ff ? csim_pkg::ST_ROOT_A_GO : csim_pkg::ST_IDLE;
         end
         csim_pkg::ST_ROOT_A_GO: begin
            state_in = csim_pkg::ST_ROOT_A_WAIT;
         end
         csim_pkg::ST_ROOT_A_WAIT: begin
            if (root_done) begin
               state_in = csim_pkg::ST_ROOT_B_GO;
            end
         end
         csim_pkg::ST_ROOT_B_GO: begin
            sa_in    = root;
            state_in = csim_pkg::ST_ROOT_B_WAIT;
         end
         csim_pkg::ST_ROOT_B_WAIT: begin
            if (root_done) begin
               state_in = csim_pkg::ST_DEN_MUL;
            end
         end
         csim_pkg::ST_DEN_MUL: begin
            state_in = csim_pkg::ST_DIV_GO;
         end
         csim_pkg::ST_DIV_GO: begin
            zero_in  = (den == '0);
            state_in = (den == '0) ? csim_pkg::ST_FINISH : csim_pkg::ST_DIV_WAIT;
         end
         csim_pkg::ST_DIV_WAIT: begin
            if (div_status.done) begin
               state_in = csim_pkg::ST_FINISH;
            end
         end
         csim_pkg::ST_FINISH: begin
            if (out_free) begin
               if (zero_ff) begin
                  sim_in = '0;
               end else if (dot_neg) begin
                  sim_in = (div_status.ovf || quo > csim_pkg::NegLimit) ?
                           csim_pkg::SimMin : $signed(quo_neg[ElemW-1:0]);
               end else begin
                  sim_in = (div_status.ovf || quo > csim_pkg::PosLimit) ?
                           csim_pkg::SimMax : $signed(quo[ElemW-1:0]);
               end
               zn_in        = zero_ff;
               rsp_valid_in = 1'b1;
               dot_in       = '0;
               na_in        = '0;
               nb_in        = '0;
               state_in     = csim_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = csim_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csim_pkg::ST_IDLE;
         dot_ff       <= '0;
         na_ff        <= '0;
         nb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dot_ff       <= dot_in;
         na_ff        <= na_in;
         nb_ff        <= nb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      last_ff <= last_in;
      sa_ff   <= sa_in;
      prod_ff <= prod_in;
      zero_ff <= zero_in;
      sim_ff  <= sim_in;
      zn_ff   <= zn_in;
   end

   csim_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (root_value),
      .done  (root_done),
      .root  (root)
   );

   csim_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (num),
      .den    (den),
      .status (div_status),
      .quo    (quo)
   );

   assign req_ready      = (state_ff == csim_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_similarity = sim_ff;
   assign rsp_zero_norm  = zn_ff;

endmodule

// ===== rtl/core/csim_port_checker.sv =====
// ----------------------------------------------------------------------------
// csim_port_checker
// Port-level checks on the cosine similarity engine, bound to the top level.
// ----------------------------------------------------------------------------
module csim_port_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic signed [csim_pkg::ElemWidth-1:0] req_elem_a,
   input logic signed [csim_pkg::ElemWidth-1:0] req_elem_b,
   input logic                                  req_last_pair,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [csim_pkg::ElemWidth-1:0] rsp_similarity,
   input logic                                  rsp_zero_norm
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_similarity) && $stable(rsp_zero_norm))
      else $error("result changed while stalled");

   // zero norm always comes with a zero similarity
   a_zero_norm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_norm |-> rsp_similarity == '0)
      else $error("zero norm with non-zero similarity");

   // an accepted request leaves the sequencer busy in the cycle after it
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on consecutive cycles");

   // a new result appears only while the sequencer is busy
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised from idle");

endmodule

bind cosine_similarity_engine csim_port_checker u_csim_port_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_similarity_engine testbench
// Streams element pairs into the engine and checks every similarity result
// against a local fixed-point model or a listed value: directed corner pairs,
// then random vectors under bursty requests and a stalling result port.
// ----------------------------------------------------------------------------
module testbench;

   typedef logic signed [csim_pkg::ElemWidth-1:0] elem_type;
   typedef longint unsigned u64_type;

   typedef struct packed {
      elem_type similarity;
      logic     zero_norm;
   } cosine_result_type;

   typedef struct {
      elem_type          a;
      elem_type          b;
      logic              last_pair;
      bit                known;
      cosine_result_type result;
   } pair_row_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_SPARSE
   } ready_mode_type;

   typedef enum int {
      VEC_INDEPENDENT,
      VEC_SAME,
      VEC_OPPOSITE,
      VEC_NEAR,
      VEC_ZERO_A,
      VEC_ZERO_B
   } vector_style_type;

   localparam int       NumDirected   = 22;
   localparam int       RandomPairs   = 1300;
   localparam int       MaxLength     = 1024;
   localparam int       WatchdogLimit = 5000;
   localparam int       DrainCycles   = 200;
   localparam longint   DotMax        = (64'sd1 <<< (csim_pkg::AccWidth - 1)) - 1;
   localparam longint   DotMin        = -DotMax - 1;
   localparam u64_type  NormMax       = (64'd1 << csim_pkg::AccWidth) - 1;
   localparam elem_type ElemMax       = 16'sh7FFF;
   localparam elem_type ElemMin       = 16'sh8000;

   logic     clock         = 1'b0;
   logic     reset         = 1'b1;
   logic     req_valid     = 1'b0;
   logic     req_ready;
   elem_type req_elem_a    = '0;
   elem_type req_elem_b    = '0;
   logic     req_last_pair = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready     = 1'b0;
   elem_type rsp_similarity;
   logic     rsp_zero_norm;

   // model state
   longint  dot_acc    = 0;
   u64_type norm_a_acc = 0;
   u64_type norm_b_acc = 0;

   cosine_result_type expected_similarities[$];
   int                error_count  = 0;
   int                quiet_cycles = 0;
   int                burst_left   = 0;
   ready_mode_type    ready_mode   = READY_ALWAYS;
   int                ready_left   = 0;

   pair_row_type directed_pairs [NumDirected];

   cosine_similarity_engine DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_elem_a    (req_elem_a),
      .req_elem_b    (req_elem_b),
      .req_last_pair (req_last_pair),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_similarity(rsp_similarity),
      .rsp_zero_norm (rsp_zero_norm)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic u64_type floor_sqrt(input u64_type n);
      u64_type root;
      u64_type trial;
      root = 0;
      // sums stay below 2^48, so the root fits in 24 bits
      for (int i = csim_pkg::RootWidth; i >= 0; i--) begin
         trial = root | (u64_type'(1) << i);
         if (trial * trial <= n) root = trial;
      end
      return root;
   endfunction

   function automatic u64_type add_norm(input u64_type acc, input elem_type x);
      u64_type sum;
      sum = acc + u64_type'(longint'(x) * longint'(x));
      return (sum > NormMax) ? NormMax : sum;
   endfunction

   task automatic step_cosine(input elem_type a, input elem_type b, input logic last_pair,
                              output bit produced, output cosine_result_type res);
      longint  dot_next;
      longint  sim;
      u64_type den;
      u64_type mag;
      u64_type quo;
      dot_next = dot_acc + longint'(a) * longint'(b);
      if (dot_next > DotMax) dot_next = DotMax;
      else if (dot_next < DotMin) dot_next = DotMin;
      dot_acc    = dot_next;
      norm_a_acc = add_norm(norm_a_acc, a);
      norm_b_acc = add_norm(norm_b_acc, b);
      produced   = last_pair;
      res        = '0;
      if (!last_pair) return;
      den = floor_sqrt(norm_a_acc) * floor_sqrt(norm_b_acc);
      if (den == 0) begin
         res.zero_norm = 1'b1;
      end else begin
         mag = (dot_acc < 0) ? u64_type'(-dot_acc) : u64_type'(dot_acc);
         // round half away from zero on the magnitude
         quo = ((mag << 15) + (den >> 1)) / den;
         if (dot_acc < 0) sim = (quo > 32768) ? -32768 : -longint'(quo);
         else sim = (quo > 32767) ? 32767 : longint'(quo);
         res.similarity = elem_type'(sim);
      end
      dot_acc    = 0;
      norm_a_acc = 0;
      norm_b_acc = 0;
   endtask

   // One request; returns at the accepting edge. Without streaming, bursts
   // of random length are followed by random gaps, waited out before return.
   task automatic send_pair(input elem_type a, input elem_type b, input logic last_pair,
                            input bit streaming, input bit known,
                            input cosine_result_type known_result);
      bit                produced;
      cosine_result_type predicted;
      int                gap;
      req_valid     <= 1'b1;
      req_elem_a    <= a;
      req_elem_b    <= b;
      req_last_pair <= last_pair;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      step_cosine(a, b, last_pair, produced, predicted);
      if (produced) begin
         if (known) predicted = known_result;
         expected_similarities = {expected_similarities, predicted};
      end
      if (streaming) return;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   function automatic elem_type random_elem();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: return ElemMin;
               1: return ElemMax;
               2: return elem_type'(0);
               3: return elem_type'(1);
               default: return elem_type'(-1);
            endcase
         end
         1: return elem_type'(int'($urandom_range(0, 511)) - 256);
         default: return elem_type'($urandom());
      endcase
   endfunction

   function automatic elem_type near_elem(input elem_type a);
      int v;
      v = int'(a) + int'($urandom_range(0, 64)) - 32;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return elem_type'(v);
   endfunction

   // result port: random phases of full rate, coin-flip and sparse ready
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 2));
         ready_left <= $urandom_range(20, 300);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
         default:      rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      cosine_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_similarities.size() == 0) begin
            $error("result with none pending: similarity %0d zero_norm %0b",
                   rsp_similarity, rsp_zero_norm);
            error_count++;
         end else begin
            want = expected_similarities.pop_front();
            if (rsp_similarity !== want.similarity) begin
               $error("similarity: expected %0d, got %0d",
                      $signed(want.similarity), rsp_similarity);
               error_count++;
            end
            if (rsp_zero_norm !== want.zero_norm) begin
               $error("zero_norm: expected %0b, got %0b", want.zero_norm, rsp_zero_norm);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("[cosine_similarity_engine] ERROR");
            $finish;
         end
      end
   end

   initial begin
      elem_type         a;
      elem_type         b;
      int               length;
      int               pick;
      int               random_sent;
      vector_style_type style;

      directed_pairs = '{
         '{0,      0,      1'b1, 1'b1, '{0,      1'b1}},  // both norms zero
         '{32767,  0,      1'b1, 1'b1, '{0,      1'b1}},
         '{0,      -32768, 1'b1, 1'b1, '{0,      1'b1}},
         '{32767,  32767,  1'b1, 1'b1, '{32767,  1'b0}},  // quotient of one clips
         '{-32768, -32768, 1'b1, 1'b1, '{32767,  1'b0}},
         '{32767,  -32768, 1'b1, 1'b1, '{-32768, 1'b0}},
         '{-32768, 32767,  1'b1, 1'b1, '{-32768, 1'b0}},
         '{1,      1,      1'b1, 1'b1, '{32767,  1'b0}},
         '{1,      -1,     1'b1, 1'b1, '{-32768, 1'b0}},
         '{32767,  -32768, 1'b0, 1'b0, '{0,      1'b0}},
         '{-32768, 32767,  1'b0, 1'b0, '{0,      1'b0}},
         '{12345,  -23456, 1'b1, 1'b0, '{0,      1'b0}},
         '{16384,  0,      1'b0, 1'b0, '{0,      1'b0}},
         '{0,      16384,  1'b1, 1'b1, '{0,      1'b0}},  // orthogonal
         '{0,      0,      1'b0, 1'b0, '{0,      1'b0}},
         '{100,    200,    1'b1, 1'b0, '{0,      1'b0}},
         '{-1,     -1,     1'b0, 1'b0, '{0,      1'b0}},
         '{32767,  -1,     1'b1, 1'b0, '{0,      1'b0}},
         '{21845,  -21846, 1'b0, 1'b0, '{0,      1'b0}},
         '{-21846, 21845,  1'b1, 1'b0, '{0,      1'b0}},
         '{0,      0,      1'b0, 1'b0, '{0,      1'b0}},
         '{0,      123,    1'b1, 1'b1, '{0,      1'b1}}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_pairs[i])
         send_pair(directed_pairs[i].a, directed_pairs[i].b, directed_pairs[i].last_pair,
                   1'b0, directed_pairs[i].known, directed_pairs[i].result);

      random_sent = 0;
      while (random_sent < RandomPairs) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) length = $urandom_range(1, 8);
         else if (pick < 95) length = $urandom_range(9, 48);
         else if (pick < 99) length = $urandom_range(49, 300);
         else length = MaxLength;
         if (length > RandomPairs - random_sent) length = RandomPairs - random_sent;
         style = vector_style_type'($urandom_range(0, VEC_ZERO_B));
         for (int k = 0; k < length; k++) begin
            a = random_elem();
            case (style)
               VEC_SAME:     b = a;
               VEC_OPPOSITE: b = -a;
               VEC_NEAR:     b = near_elem(a);
               VEC_ZERO_A: begin
                  b = a;
                  a = '0;
               end
               VEC_ZERO_B:   b = '0;
               default:      b = random_elem();
            endcase
            send_pair(a, b, k == length - 1, 1'b0, 1'b0, '0);
            random_sent++;
         end
      end

      req_valid <= 1'b0;
      while (expected_similarities.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0) $display("[cosine_similarity_engine] OK");
      else $display("[cosine_similarity_engine] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/csim_pkg.sv
rtl/core/csim_isqrt.sv
rtl/core/csim_div.sv
rtl/core/cosine_similarity_engine.sv
rtl/core/csim_port_checker.sv
dv/testbench.sv
